[rtl/core/wfba_pkg.sv]
package wfba_pkg;

    // Fixed field widths of the item and result beats.
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned IDX_W    = 16;
    localparam int unsigned PIX_W    = 32;
    localparam int unsigned WT_W     = 9;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LANE_W   = 16;
    localparam int unsigned MAX_LANES = 4;

    // Number of distinct word addresses that the index field can carry.
    localparam int unsigned IDX_SPAN = 1 << IDX_W;

    // Defaults for the top-level parameters.
    localparam int unsigned ACCUM_WORDS_DEFAULT = 65536;
    localparam int unsigned LANES_DEFAULT       = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ACCUM = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

endpackage

[rtl/core/wfba_in_if.sv]
interface wfba_in_if;
    logic                             valid;
    logic                             ready;
    logic [wfba_pkg::OPCODE_W-1:0]    opcode;
    logic [wfba_pkg::IDX_W-1:0]       word_index;
    logic [wfba_pkg::PIX_W-1:0]       pixel_bytes;
    logic [wfba_pkg::WT_W-1:0]        weight;

    modport source (
        output valid,
        output opcode,
        output word_index,
        output pixel_bytes,
        output weight,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  word_index,
        input  pixel_bytes,
        input  weight,
        output ready
    );
endinterface

[rtl/core/wfba_out_if.sv]
interface wfba_out_if;
    logic                         valid;
    logic                         ready;
    logic [wfba_pkg::PIX_W-1:0]   out_bytes;
    logic [wfba_pkg::IDX_W-1:0]   out_index;

    modport source (
        output valid,
        output out_bytes,
        output out_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_bytes,
        input  out_index,
        output ready
    );
endinterface

[rtl/core/wfba_ram.sv]
module wfba_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = wfba_pkg::ACCUM_WORDS_DEFAULT,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read in the same cycle as a write to the same word returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/weighted_frame_blur_accumulator_top.sv]
// Weighted frame accumulator for temporal blur.
// The sample channel carries one beat per pixel word: an opcode, a word index,
// four pixel bytes and a per-frame weight. A load writes byte times weight into
// each 16-bit lane of the addressed word; an accumulate adds the weighted bytes
// into the stored lanes, each lane wrapping at 16 bits; a read-out returns the
// top byte of every lane on the result channel, together with the word index
// as it was given. Loads, accumulates and the unused opcode return nothing.
// A word must be loaded before it is accumulated into or read out.
// Throughput is one beat per cycle for any mix of opcodes and addresses, unless
// the receiver stalls the result channel; the separate read and write ports of
// the lane memory allow one read-modify-write per cycle, and a forwarding
// register covers a word that is touched by two beats in a row.
// A read-out result passes through every pipeline stage and the output register.
// Reset empties the pipeline and the output register but leaves the lane
// memory untouched, so no clearing pass is needed and a beat may be accepted
// as soon as reset is released. When the receiver holds ready low with a
// result waiting, the whole pipeline stalls in place and sample ready drops;
// nothing is lost or repeated.
module weighted_frame_blur_accumulator_top #(
    parameter int unsigned ACCUM_WORDS = wfba_pkg::ACCUM_WORDS_DEFAULT,
    parameter int unsigned LANES       = wfba_pkg::LANES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    wfba_in_if.sink      sample,
    wfba_out_if.source   result
);

    localparam int unsigned AW     = (ACCUM_WORDS > 1) ? $clog2(ACCUM_WORDS) : 1;
    localparam int unsigned LANE_W = wfba_pkg::LANE_W;
    localparam int unsigned BYTE_W = wfba_pkg::BYTE_W;
    localparam int unsigned IDX_W  = wfba_pkg::IDX_W;
    localparam int unsigned MEM_W  = LANES * LANE_W;

    // The whole pipeline moves together; it only holds when a result is
    // waiting in the output register and the receiver is not taking it.
    logic pipe_advance;

    // Stage one: the accepted beat.
    logic                          p1_valid_reg;
    logic [wfba_pkg::OPCODE_W-1:0] p1_op_reg;
    logic [IDX_W-1:0]              p1_idx_reg;
    logic [wfba_pkg::PIX_W-1:0]    p1_pix_reg;
    logic [wfba_pkg::WT_W-1:0]     p1_wt_reg;

    // Stage two: the word address and the weighted lane products.
    logic                          p2_valid_reg;
    logic [wfba_pkg::OPCODE_W-1:0] p2_op_reg;
    logic [IDX_W-1:0]              p2_idx_reg;
    logic [AW-1:0]                 p2_addr_reg;
    logic [AW-1:0]                 p2_addr_next;
    logic [LANE_W-1:0]             p2_prod_reg  [LANES];
    logic [LANE_W-1:0]             p2_prod_next [LANES];

    // Stage three: memory data arrives, the lanes are updated and written back.
    logic                          p3_valid_reg;
    logic [wfba_pkg::OPCODE_W-1:0] p3_op_reg;
    logic [IDX_W-1:0]              p3_idx_reg;
    logic [AW-1:0]                 p3_addr_reg;
    logic [LANE_W-1:0]             p3_prod_reg [LANES];

    logic [MEM_W-1:0]              ram_rdata;
    logic [MEM_W-1:0]              p3_old;
    logic [MEM_W-1:0]              p3_new;
    logic                          p3_write;

    // The last word written. The memory returns old data for a read that
    // coincides with a write, so the following beat takes the word from here.
    logic                          fwd_valid_reg;
    logic [AW-1:0]                 fwd_addr_reg;
    logic [MEM_W-1:0]              fwd_data_reg;

    // Output register.
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [wfba_pkg::PIX_W-1:0]    out_bytes_reg;
    logic [wfba_pkg::PIX_W-1:0]    out_bytes_next;
    logic [IDX_W-1:0]              out_index_reg;

    assign pipe_advance = !out_valid_reg || result.ready;
    assign sample.ready = pipe_advance;

    // ------------------------------------------------------------------
    // Word address: the index modulo the memory depth. A depth that covers
    // the whole index range takes the index as it is; a smaller one uses a
    // reciprocal multiplication (exact for 16-bit indices) in stage one and
    // the back-multiplication and subtraction in stage two.
    // ------------------------------------------------------------------
    if (ACCUM_WORDS >= wfba_pkg::IDX_SPAN)
    begin : g_addr_direct
        assign p2_addr_next = AW'(p1_idx_reg);
    end
    else
    begin : g_addr_mod
        localparam logic [32:0] RECIP =
            33'(((64'd1 << 32) + 64'(ACCUM_WORDS) - 64'd1) / 64'(ACCUM_WORDS));

        logic [48:0]      quot_full;
        logic [IDX_W-1:0] quot_next;
        logic [IDX_W-1:0] quot_reg;
        logic [31:0]      back_prod;
        logic [31:0]      rem;

        assign quot_full = 49'(sample.word_index) * 49'(RECIP);
        assign quot_next = quot_full[47:32];

        always_ff @(posedge clk)
        begin
            if (pipe_advance)
            begin
                quot_reg <= quot_next;
            end
        end

        assign back_prod    = 32'(quot_reg) * 32'(ACCUM_WORDS);
        assign rem          = 32'(p1_idx_reg) - back_prod;
        assign p2_addr_next = rem[AW-1:0];
    end

    // Weighted products, kept to 16 bits as the lane hardware keeps them.
    always_comb
    begin
        logic [16:0] prod_full;
        prod_full = '0;
        for (int k = 0; k < LANES; k++)
        begin
            prod_full = 17'(p1_pix_reg[BYTE_W*k +: BYTE_W]) * 17'(p1_wt_reg);
            p2_prod_next[k] = prod_full[LANE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Lane update. The read for the beat now in stage three was issued when
    // it entered that stage.
    // ------------------------------------------------------------------
    assign p3_old = (fwd_valid_reg && (fwd_addr_reg == p3_addr_reg)) ? fwd_data_reg
                                                                      : ram_rdata;

    always_comb
    begin
        p3_new = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (p3_op_reg == wfba_pkg::OP_LOAD)
            begin
                p3_new[LANE_W*k +: LANE_W] = p3_prod_reg[k];
            end
            else
            begin
                p3_new[LANE_W*k +: LANE_W] = p3_old[LANE_W*k +: LANE_W] + p3_prod_reg[k];
            end
        end
    end

    assign p3_write = pipe_advance && p3_valid_reg &&
                      ((p3_op_reg == wfba_pkg::OP_LOAD) || (p3_op_reg == wfba_pkg::OP_ACCUM));

    wfba_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ACCUM_WORDS)
    ) u_lane_ram (
        .clk   (clk),
        .we    (p3_write),
        .waddr (p3_addr_reg),
        .wdata (p3_new),
        .re    (pipe_advance),
        .raddr (p2_addr_reg),
        .rdata (ram_rdata)
    );

    // Read-out: the top byte of each lane. Lanes beyond LANES read as zero.
    always_comb
    begin
        out_bytes_next = '0;
        for (int k = 0; k < LANES; k++)
        begin
            out_bytes_next[BYTE_W*k +: BYTE_W] = p3_old[LANE_W*k + BYTE_W +: BYTE_W];
        end
    end

    assign out_valid_next = p3_valid_reg && (p3_op_reg == wfba_pkg::OP_READ);

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (pipe_advance)
            begin
                p1_valid_reg  <= sample.valid;
                p2_valid_reg  <= p1_valid_reg;
                p3_valid_reg  <= p2_valid_reg;
                out_valid_reg <= out_valid_next;
            end
            if (p3_write)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pipe_advance)
        begin
            p1_op_reg   <= sample.opcode;
            p1_idx_reg  <= sample.word_index;
            p1_pix_reg  <= sample.pixel_bytes;
            p1_wt_reg   <= sample.weight;

            p2_op_reg   <= p1_op_reg;
            p2_idx_reg  <= p1_idx_reg;
            p2_addr_reg <= p2_addr_next;
            p2_prod_reg <= p2_prod_next;

            p3_op_reg   <= p2_op_reg;
            p3_idx_reg  <= p2_idx_reg;
            p3_addr_reg <= p2_addr_reg;
            p3_prod_reg <= p2_prod_reg;

            out_bytes_reg <= out_bytes_next;
            out_index_reg <= p3_idx_reg;
        end
        if (p3_write)
        begin
            fwd_addr_reg <= p3_addr_reg;
            fwd_data_reg <= p3_new;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_bytes = out_bytes_reg;
    assign result.out_index = out_index_reg;

endmodule
